// ===== hdl/crs_pkg.sv =====
package crs_pkg;

  // Field widths of the item formats
  localparam int XW     = 9;
  localparam int YW     = 8;
  localparam int SCW    = 16;
  localparam int RADW   = 18;
  localparam int SLOTW  = 6;
  localparam int ECNTW  = 7;
  // Squared distance: 511^2 + 255^2 fits in 19 bits
  localparam int D2W    = 2 * XW + 1;

  localparam int MAX_CORNERS_DEF = 64;
  localparam logic [RADW-1:0] RADIUS_RST = RADW'(225);

  typedef enum logic [1:0] {
    ST_APPEND  = 2'd0,
    ST_REPLACE = 2'd1,
    ST_KEEP    = 2'd2,
    ST_DROP    = 2'd3
  } status_t;

  typedef struct packed {
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
    logic [SCW-1:0] score;
  } corner_t;

  typedef struct packed {
    logic           frame_start;
    logic [XW-1:0]  x_coord;
    logic [YW-1:0]  y_coord;
    logic [SCW-1:0] corner_score;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [SLOTW-1:0] slot;
    logic [XW-1:0]    kept_x;
    logic [YW-1:0]    kept_y;
    logic [SCW-1:0]   kept_score;
    logic [ECNTW-1:0] entry_count;
  } out_item_t;

  // Table write request from the sequencer
  typedef struct packed {
    logic    en;
    corner_t data;
  } tbl_wr_t;

  // One compared entry coming back from the distance unit
  typedef struct packed {
    logic    valid;
    logic    hit;
    corner_t entry;
  } scan_res_t;

endpackage

// ===== hdl/corner_radius_suppression_top.sv =====
// Radius non-maximum suppression of corners. Each corner item is compared with the
// stored corners oldest first, one entry per cycle through the table's single read
// port into one pipelined distance unit (abs difference, squares, sum and compare).
// The scan ends at the first matching entry, or after all N stored entries miss;
// with an empty table it ends without a read. A new item is taken once the result
// sits in the output register, even if that result is still stalled. The table is
// not cleared at reset: only entries below the stored count are read, and frame_start
// empties the table as its item is accepted.
module corner_radius_suppression_top import crs_pkg::*; #(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [RADW-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_CORNERS);

  logic            flush;
  logic [RADW-1:0] radius_sq;
  logic [XW-1:0]   qx;
  logic [YW-1:0]   qy;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  tbl_wr_t         wr;
  logic [IW-1:0]   wr_addr;
  logic            rd_valid;
  logic [IW-1:0]   rd_idx;
  corner_t         rd_data;
  scan_res_t       res;
  logic [IW-1:0]   res_idx;

  // register writes are taken at any time
  assign cfg_ready = 1'b1;

  crs_ctrl #(.MAX_CORNERS(MAX_CORNERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .flush     (flush),
    .radius_sq (radius_sq),
    .qx        (qx),
    .qy        (qy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .res       (res),
    .res_idx   (res_idx)
  );

  crs_table #(.MAX_CORNERS(MAX_CORNERS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_valid (rd_valid),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data)
  );

  crs_dist #(.MAX_CORNERS(MAX_CORNERS)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (flush),
    .radius_sq (radius_sq),
    .qx        (qx),
    .qy        (qy),
    .rd_valid  (rd_valid),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .res       (res),
    .res_idx   (res_idx)
  );

endmodule

// ===== hdl/crs_table.sv =====
module crs_table import crs_pkg::*; #(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           flush,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_CORNERS)-1:0] rd_addr,
  input  tbl_wr_t                        wr,
  input  logic [$clog2(MAX_CORNERS)-1:0] wr_addr,
  output logic                           rd_valid,
  output logic [$clog2(MAX_CORNERS)-1:0] rd_idx,
  output corner_t                        rd_data
);

  localparam int IW = $clog2(MAX_CORNERS);

  corner_t         mem [MAX_CORNERS];
  corner_t         rd_data_r;
  logic [IW-1:0]   rd_idx_r;
  logic            rd_valid_r;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  // Read tag valid, dropped on flush
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_idx   = rd_idx_r;
  assign rd_data  = rd_data_r;

endmodule

// ===== hdl/crs_dist.sv =====
module crs_dist import crs_pkg::*; #(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           flush,
  input  logic [RADW-1:0]                radius_sq,
  input  logic [XW-1:0]                  qx,
  input  logic [YW-1:0]                  qy,
  input  logic                           rd_valid,
  input  logic [$clog2(MAX_CORNERS)-1:0] rd_idx,
  input  corner_t                        rd_data,
  output scan_res_t                      res,
  output logic [$clog2(MAX_CORNERS)-1:0] res_idx
);

  localparam int IW = $clog2(MAX_CORNERS);

  // stage 1: absolute differences
  logic            v1_r;
  logic [IW-1:0]   idx1_r;
  corner_t         e1_r;
  logic [XW-1:0]   dx1_r;
  logic [YW-1:0]   dy1_r;
  // stage 2: squares
  logic            v2_r;
  logic [IW-1:0]   idx2_r;
  corner_t         e2_r;
  logic [2*XW-1:0] dxsq2_r;
  logic [2*YW-1:0] dysq2_r;
  // stage 3: sum and compare
  logic            v3_r;
  logic            hit3_r;
  logic [IW-1:0]   idx3_r;
  corner_t         e3_r;

  logic [XW-1:0]   dx;
  logic [YW-1:0]   dy;
  logic [D2W-1:0]  d2;

  always_comb begin
    dx = (rd_data.x > qx) ? rd_data.x - qx : qx - rd_data.x;
    dy = (rd_data.y > qy) ? rd_data.y - qy : qy - rd_data.y;
    d2 = D2W'(dxsq2_r) + D2W'(dysq2_r);
  end

  // Payload of the three stages
  always_ff @(posedge clk) begin
    idx1_r  <= rd_idx;
    e1_r    <= rd_data;
    dx1_r   <= dx;
    dy1_r   <= dy;
    idx2_r  <= idx1_r;
    e2_r    <= e1_r;
    dxsq2_r <= dx1_r * dx1_r;
    dysq2_r <= dy1_r * dy1_r;
    idx3_r  <= idx2_r;
    e3_r    <= e2_r;
    hit3_r  <= (d2 <= D2W'(radius_sq));
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= rd_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.valid = v3_r;
  assign res.hit   = hit3_r;
  assign res.entry = e3_r;
  assign res_idx   = idx3_r;

endmodule

// ===== hdl/crs_ctrl.sv =====
module crs_ctrl import crs_pkg::*; #(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  in_item_t                       in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output out_item_t                      out_data,
  // radius register write
  input  logic                           cfg_wr,
  input  logic [RADW-1:0]                cfg_data,
  // table and distance unit
  output logic                           flush,
  output logic [RADW-1:0]                radius_sq,
  output logic [XW-1:0]                  qx,
  output logic [YW-1:0]                  qy,
  output logic                           rd_en,
  output logic [$clog2(MAX_CORNERS)-1:0] rd_addr,
  output tbl_wr_t                        wr,
  output logic [$clog2(MAX_CORNERS)-1:0] wr_addr,
  input  scan_res_t                      res,
  input  logic [$clog2(MAX_CORNERS)-1:0] res_idx
);

  localparam int IW = $clog2(MAX_CORNERS);
  localparam int CW = $clog2(MAX_CORNERS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   issue_r, issue_nxt;
  in_item_t        item_r;
  logic [RADW-1:0] radius_r;
  out_item_t       dec_r, dec_nxt;
  logic            dec_wr_r, dec_wr_nxt;
  logic [IW-1:0]   dec_addr_r, dec_addr_nxt;
  out_item_t       out_r;
  logic            out_valid_r;

  logic            accept;
  logic            out_load;
  logic            end_hit;
  logic            end_miss;
  logic            full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign full     = (cnt_r == CW'(MAX_CORNERS));

  // scan ends at the first match, or after the newest entry misses
  assign end_hit  = (state_r == S_SCAN) && res.valid && res.hit;
  assign end_miss = (state_r == S_SCAN) &&
                    ((cnt_r == '0) ||
                     (res.valid && !res.hit && (CW'(res_idx) + CW'(1)) == cnt_r));

  // Sequencer and decision
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    issue_nxt    = issue_r;
    dec_nxt      = dec_r;
    dec_wr_nxt   = dec_wr_r;
    dec_addr_nxt = dec_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          issue_nxt = '0;
          if (in_data.frame_start) begin
            cnt_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (end_hit || end_miss) begin
          state_nxt = S_DONE;
        end
        priority if (end_hit) begin
          dec_nxt.slot        = SLOTW'(res_idx);
          dec_nxt.entry_count = ECNTW'(cnt_r);
          dec_addr_nxt        = res_idx;
          if (item_r.corner_score > res.entry.score) begin
            dec_nxt.status     = ST_REPLACE;
            dec_nxt.kept_x     = item_r.x_coord;
            dec_nxt.kept_y     = item_r.y_coord;
            dec_nxt.kept_score = item_r.corner_score;
            dec_wr_nxt         = 1'b1;
          end else begin
            dec_nxt.status     = ST_KEEP;
            dec_nxt.kept_x     = res.entry.x;
            dec_nxt.kept_y     = res.entry.y;
            dec_nxt.kept_score = res.entry.score;
            dec_wr_nxt         = 1'b0;
          end
        end else if (end_miss && full) begin
          dec_nxt.status      = ST_DROP;
          dec_nxt.slot        = '0;
          dec_nxt.kept_x      = '0;
          dec_nxt.kept_y      = '0;
          dec_nxt.kept_score  = '0;
          dec_nxt.entry_count = ECNTW'(cnt_r);
          dec_wr_nxt          = 1'b0;
        end else if (end_miss) begin
          dec_nxt.status      = ST_APPEND;
          dec_nxt.slot        = SLOTW'(cnt_r);
          dec_nxt.kept_x      = item_r.x_coord;
          dec_nxt.kept_y      = item_r.y_coord;
          dec_nxt.kept_score  = item_r.corner_score;
          dec_nxt.entry_count = ECNTW'(cnt_r + CW'(1));
          dec_addr_nxt        = cnt_r[IW-1:0];
          dec_wr_nxt          = 1'b1;
          cnt_nxt             = cnt_r + CW'(1);
        end else begin
          dec_wr_nxt = dec_wr_r;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= '0;
      radius_r    <= RADIUS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      issue_r <= issue_nxt;
      if (cfg_wr) begin
        radius_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    dec_r      <= dec_nxt;
    dec_wr_r   <= dec_wr_nxt;
    dec_addr_r <= dec_addr_nxt;
    if (out_load) begin
      out_r <= dec_r;
    end
  end

  // one read issued per cycle until all stored entries are in flight
  assign rd_en     = (state_r == S_SCAN) && (issue_r < cnt_r);
  assign rd_addr   = issue_r[IW-1:0];
  assign flush     = (state_r != S_SCAN);
  assign radius_sq = radius_r;
  assign qx        = item_r.x_coord;
  assign qy        = item_r.y_coord;

  // table update when the result is handed over
  assign wr.en         = out_load && dec_wr_r;
  assign wr.data.x     = item_r.x_coord;
  assign wr.data.y     = item_r.y_coord;
  assign wr.data.score = item_r.corner_score;
  assign wr_addr       = dec_addr_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_CORNERS))
    else $error("stored count beyond table depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= cnt_r || state_r != S_SCAN)
    else $error("scan issued past stored entries");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accepted item did not start a scan");

  a_wr_done: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_DONE && out_load))
    else $error("table write outside result handoff");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after handoff");
`endif

endmodule
